// ----- rtl/rpp_pkg.sv -----
package rpp_pkg;

  // Field and datapath widths
  localparam int unsigned COORD_W = 25;
  localparam int unsigned DIR_W   = 18;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned CW      = 36;           // CORDIC x/y datapath
  localparam int unsigned MA      = 36;           // multiplier operand a
  localparam int unsigned MB      = 27;           // multiplier operand b
  localparam int unsigned MP      = MA + MB;      // full product
  localparam int unsigned STEP_W  = 5;            // covers up to 32 iterations
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TDATA_W = 56;

  // Fixed-point scaling
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned DIST_SHIFT = 26;
  localparam int unsigned OFF_SHIFT  = 16 + FRAC_BITS;
  localparam int unsigned DIR_SHIFT  = 14;
  localparam int unsigned NORM_BIT   = 30;
  localparam int unsigned SUM_W      = MP - OFF_SHIFT + 1;

  localparam logic signed [MP-1:0] DIST_HALF = MP'(64'd1 << (DIST_SHIFT - 1));
  localparam logic signed [MP-1:0] OFF_HALF  = MP'(64'd1 << (OFF_SHIFT - 1));
  localparam logic signed [CW-1:0] DIR_HALF  = CW'(64'd1 << (DIR_SHIFT - 1));

  localparam logic signed [DIR_W-1:0]   ONE_Q16   = 18'sd65536;
  localparam logic signed [DIR_W-1:0]   MONE_Q16  = -18'sd65536;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 25'sd16777215;
  localparam logic signed [COORD_W-1:0] COORD_MIN = -25'sd16777216;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_A0X  = 3'd1;
  localparam logic [2:0] REG_A0Y  = 3'd2;
  localparam logic [2:0] REG_A1X  = 3'd3;
  localparam logic [2:0] REG_A1Y  = 3'd4;

  typedef enum logic [2:0] {
    COP_HOLD,
    COP_LOAD,
    COP_NORM,
    COP_FLIP,
    COP_VEC,
    COP_ROT
  } cordic_op_e;

  typedef struct packed {
    cordic_op_e        op;
    logic [STEP_W-1:0] step;
  } cordic_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_FLIP,
    ST_VEC,
    ST_ROTLD,
    ST_ROT,
    ST_DIR,
    ST_MULD,
    ST_DIST,
    ST_MULX,
    ST_MULY,
    ST_OUT
  } state_e;

  // Floor quotient by shift and subtract, for elaboration-time constants
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Inverse CORDIC gain in Q26, evaluated at elaboration
  function automatic logic [63:0] gain_inv_q26(input int unsigned steps);
    logic [63:0] p;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] bv;
    p = 64'd1 << 52;
    for (int i = 0; i < 24; i++) begin
      if (i < steps) begin
        p = p - udiv64(p, (64'd1 << (2 * i)) + 64'd1);
      end
    end
    n  = p;
    r  = 64'd0;
    bv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (n >= r + bv) begin
        n = n - (r + bv);
        r = (r >> 1) + bv;
      end else begin
        r = r >> 1;
      end
      bv = bv >> 2;
    end
    return r;
  endfunction

  // Saturate a wide sum to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(COORD_MAX)) begin
      return COORD_MAX;
    end else if (v < SUM_W'(COORD_MIN)) begin
      return COORD_MIN;
    end
    return v[COORD_W-1:0];
  endfunction

  // Round a Q30 direction component to Q16 and clamp to +-1
  function automatic logic signed [DIR_W-1:0] round_dir(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + DIR_HALF) >>> DIR_SHIFT;
    if (r > CW'(ONE_Q16)) begin
      return ONE_Q16;
    end else if (r < CW'(MONE_Q16)) begin
      return MONE_Q16;
    end
    return r[DIR_W-1:0];
  endfunction

endpackage

// ----- rtl/ruler_point_projector.sv -----
// Ruler point projector. A click transaction (tuser = 0) stores the point as the click point
// and sets the ruler direction: from anchor 0 to the click in circle mode, from anchor 0 to
// anchor 1 in parallel mode; a zero vector gives direction (1, 0). A map transaction
// (tuser = 1) returns click + |p - click| * direction, saturated to signed Q16.8. One shared
// CORDIC stage does one micro-rotation per cycle and one 36x27 multiplier is reused for the
// distance and both output components, so the block takes one item at a time. A map item
// goes through the flip, vectoring and multiply states to the output register, later while
// the previous result still waits there; the input is ready again as the result enters it.
// A click item keeps the input off while its vector is doubled until the larger component
// reaches 2^30 (6 to 30 doublings) and the direction is set. A zero-vector click is done at
// acceptance. A finished result waits in the output register as the next item is accepted.
// Users must write anchors and mode over APB only while idle; this is not enforced.
module ruler_point_projector #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rpp_pkg::ADDR_W-1:0]        paddr,
  input  logic [rpp_pkg::DATA_W-1:0]        pwdata,
  output logic [rpp_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rpp_pkg::TDATA_W-1:0]       s_axis_tdata,  // pos_x[24:0], pos_y[49:25]
  input  logic                              s_axis_tuser,  // action
  // Output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rpp_pkg::TDATA_W-1:0]       m_axis_tdata   // snap_x[24:0], snap_y[49:25]
);
  import rpp_pkg::*;

  localparam logic [MB-1:0]        K_Q26   = MB'(gain_inv_q26(CORDIC_STEPS));
  localparam logic signed [CW-1:0] K_Q30   = CW'(gain_inv_q26(CORDIC_STEPS) << 4);
  localparam logic [STEP_W-1:0]    LAST_ST = STEP_W'(CORDIC_STEPS - 1);

  state_e                      state_q, state_d;
  logic [STEP_W-1:0]           step_q, step_d;
  logic                        is_map_q;
  logic                        mode_q;
  logic signed [COORD_W-1:0]   a0x_q, a0y_q, a1x_q, a1y_q;
  logic signed [COORD_W-1:0]   click_x_q, click_y_q;
  logic signed [DIR_W-1:0]     dir_cos_q, dir_sin_q;
  logic signed [MA-1:0]        d_q;
  logic signed [COORD_W-1:0]   res_x_q;
  logic signed [COORD_W-1:0]   out_x_q, out_y_q;
  logic                        m_valid_q;

  logic                        cfg_wr;
  logic                        in_acc;
  logic                        action;
  logic signed [COORD_W-1:0]   pos_x, pos_y;
  logic signed [DIFF_W-1:0]    map_dx, map_dy, set_dx, set_dy;
  logic                        set_zero;
  cordic_ctl_t                 ctl;
  logic signed [CW-1:0]        load_x, load_y;
  logic signed [CW-1:0]        cx, cy;
  logic                        cflip, norm_done;
  logic                        mul_en;
  logic signed [MA-1:0]        mul_a;
  logic signed [MB-1:0]        mul_b;
  logic signed [MP-1:0]        prod;
  logic signed [MP-1:0]        dist_full, off_full;
  logic signed [SUM_W-1:0]     off_ext, click_sel, comp_sum;
  logic signed [CW-1:0]        c_adj, s_adj;
  logic                        dist_en, res_x_en, dir_en, out_load, out_free;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[4:2])
      REG_MODE: prdata = {{(DATA_W-1){1'b0}}, mode_q};
      REG_A0X:  prdata = DATA_W'(a0x_q);
      REG_A0Y:  prdata = DATA_W'(a0y_q);
      REG_A1X:  prdata = DATA_W'(a1x_q);
      REG_A1Y:  prdata = DATA_W'(a1y_q);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      a0x_q  <= '0;
      a0y_q  <= '0;
      a1x_q  <= '0;
      a1y_q  <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MODE: mode_q <= pwdata[0];
        REG_A0X:  a0x_q  <= pwdata[COORD_W-1:0];
        REG_A0Y:  a0y_q  <= pwdata[COORD_W-1:0];
        REG_A1X:  a1x_q  <= pwdata[COORD_W-1:0];
        REG_A1Y:  a1y_q  <= pwdata[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input unpacking and difference vectors
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign action        = s_axis_tuser;
  assign pos_x         = s_axis_tdata[COORD_W-1:0];
  assign pos_y         = s_axis_tdata[2*COORD_W-1:COORD_W];

  assign map_dx   = DIFF_W'(pos_x) - DIFF_W'(click_x_q);
  assign map_dy   = DIFF_W'(pos_y) - DIFF_W'(click_y_q);
  assign set_dx   = (mode_q ? DIFF_W'(a1x_q) : DIFF_W'(pos_x)) - DIFF_W'(a0x_q);
  assign set_dy   = (mode_q ? DIFF_W'(a1y_q) : DIFF_W'(pos_y)) - DIFF_W'(a0y_q);
  assign set_zero = (set_dx == '0) && (set_dy == '0);

  rpp_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .load_x_i   (load_x),
    .load_y_i   (load_y),
    .x_o        (cx),
    .y_o        (cy),
    .flip_o     (cflip),
    .norm_done_o(norm_done)
  );

  rpp_mult u_mult (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  // Sequencer: next state and datapath controls
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    ctl.op   = COP_HOLD;
    ctl.step = step_q;
    load_x   = action ? (CW'(map_dx) <<< FRAC_BITS) : CW'(set_dx);
    load_y   = action ? (CW'(map_dy) <<< FRAC_BITS) : CW'(set_dy);
    mul_en   = 1'b0;
    mul_a    = d_q;
    mul_b    = MB'(dir_cos_q);
    dist_en  = 1'b0;
    res_x_en = 1'b0;
    dir_en   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ctl.op = COP_LOAD;
          step_d = '0;
          if (action) begin
            state_d = ST_FLIP;
          end else if (!set_zero) begin
            state_d = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (norm_done) begin
          ctl.op  = COP_FLIP;
          state_d = ST_VEC;
        end else begin
          ctl.op = COP_NORM;
        end
      end
      ST_FLIP: begin
        ctl.op  = COP_FLIP;
        state_d = ST_VEC;
      end
      ST_VEC: begin
        ctl.op = COP_VEC;
        if (step_q == LAST_ST) begin
          step_d  = '0;
          state_d = is_map_q ? ST_MULD : ST_ROTLD;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_ROTLD: begin
        ctl.op  = COP_LOAD;
        load_x  = K_Q30;
        load_y  = '0;
        state_d = ST_ROT;
      end
      ST_ROT: begin
        ctl.op = COP_ROT;
        if (step_q == LAST_ST) begin
          step_d  = '0;
          state_d = ST_DIR;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DIR: begin
        dir_en  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_MULD: begin
        mul_en  = 1'b1;
        mul_a   = cx;
        mul_b   = K_Q26;
        state_d = ST_DIST;
      end
      ST_DIST: begin
        dist_en = 1'b1;
        state_d = ST_MULX;
      end
      ST_MULX: begin
        mul_en  = 1'b1;
        state_d = ST_MULY;
      end
      ST_MULY: begin
        mul_en   = 1'b1;
        mul_b    = MB'(dir_sin_q);
        res_x_en = 1'b1;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Rounding of distance and offsets
  assign dist_full = (prod + DIST_HALF) >>> DIST_SHIFT;
  assign off_full  = (prod + OFF_HALF) >>> OFF_SHIFT;
  assign off_ext   = off_full[SUM_W-1:0];
  assign click_sel = (state_q == ST_MULY) ? SUM_W'(click_x_q) : SUM_W'(click_y_q);
  assign comp_sum  = click_sel + off_ext;

  // Direction from the replayed rotation, undoing the half-plane flip
  assign c_adj = cflip ? -cx : cx;
  assign s_adj = cflip ? -cy : cy;

  // Click point, direction and item kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      click_x_q <= '0;
      click_y_q <= '0;
      dir_cos_q <= ONE_Q16;
      dir_sin_q <= '0;
      is_map_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        is_map_q <= action;
        if (!action) begin
          click_x_q <= pos_x;
          click_y_q <= pos_y;
          if (set_zero) begin
            dir_cos_q <= ONE_Q16;
            dir_sin_q <= '0;
          end
        end
      end
      if (dir_en) begin
        dir_cos_q <= round_dir(c_adj);
        dir_sin_q <= round_dir(s_adj);
      end
    end
  end

  // Distance and first component
  always_ff @(posedge clk_i) begin
    if (dist_en) begin
      d_q <= dist_full[MA-1:0];
    end
    if (res_x_en) begin
      res_x_q <= sat_coord(comp_sum);
    end
  end

  // Output register: hold until the transaction completes
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q <= res_x_q;
      out_y_q <= sat_coord(comp_sum);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(TDATA_W-2*COORD_W){1'b0}}, out_y_q, out_x_q};

  // A new result appears only from the output step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result raised outside the output step");

  // Direction components stay within the unit range
  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dir_cos_q <= ONE_Q16) && (dir_cos_q >= MONE_Q16) &&
    (dir_sin_q <= ONE_Q16) && (dir_sin_q >= MONE_Q16))
    else $error("direction out of range");

  // Vectoring leaves a non-negative magnitude for the distance multiply
  a_mag_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MULD) |-> !cx[CW-1])
    else $error("negative magnitude after vectoring");

  // Iteration counter never runs past the last step
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_VEC) || (state_q == ST_ROT)) |-> (step_q <= LAST_ST))
    else $error("iteration counter overrun");

endmodule

// ----- rtl/rpp_cordic.sv -----
module rpp_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic                          clk_i,
  input  rpp_pkg::cordic_ctl_t          ctl_i,
  input  logic signed [rpp_pkg::CW-1:0] load_x_i,
  input  logic signed [rpp_pkg::CW-1:0] load_y_i,
  output logic signed [rpp_pkg::CW-1:0] x_o,
  output logic signed [rpp_pkg::CW-1:0] y_o,
  output logic                          flip_o,
  output logic                          norm_done_o
);
  import rpp_pkg::*;

  localparam int unsigned IW = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [CW-1:0] xs, ys;
  logic [STEPS-1:0]     dirs_q, dirs_d;
  logic                 flip_q, flip_d;
  logic                 neg;

  // Magnitude strictly below 2^30
  function automatic logic is_small(input logic signed [CW-1:0] v);
    return (v[CW-1:NORM_BIT] == '0) ||
           ((v[CW-1:NORM_BIT] == '1) && (v[NORM_BIT-1:0] != '0));
  endfunction

  // One micro-rotation, load, doubling or flip per cycle
  always_comb begin
    xs     = x_q >>> ctl_i.step;
    ys     = y_q >>> ctl_i.step;
    neg    = (ctl_i.op == COP_ROT) ? dirs_q[ctl_i.step[IW-1:0]] : y_q[CW-1];
    x_d    = x_q;
    y_d    = y_q;
    dirs_d = dirs_q;
    flip_d = flip_q;
    case (ctl_i.op)
      COP_LOAD: begin
        x_d = load_x_i;
        y_d = load_y_i;
      end
      COP_NORM: begin
        x_d = x_q <<< 1;
        y_d = y_q <<< 1;
      end
      COP_FLIP: begin
        flip_d = x_q[CW-1];
        if (x_q[CW-1]) begin
          x_d = -x_q;
          y_d = -y_q;
        end
      end
      COP_VEC, COP_ROT: begin
        if (ctl_i.op == COP_VEC) begin
          dirs_d[ctl_i.step[IW-1:0]] = ~y_q[CW-1];
        end
        if (neg) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    dirs_q <= dirs_d;
    flip_q <= flip_d;
  end

  assign x_o         = x_q;
  assign y_o         = y_q;
  assign flip_o      = flip_q;
  assign norm_done_o = !(is_small(x_q) && is_small(y_q));

endmodule

// ----- rtl/rpp_mult.sv -----
module rpp_mult (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [rpp_pkg::MA-1:0] a_i,
  input  logic signed [rpp_pkg::MB-1:0] b_i,
  output logic signed [rpp_pkg::MP-1:0] prod_o
);
  import rpp_pkg::*;

  logic signed [MP-1:0] prod_q;

  // Register every product before it is used
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import rpp_pkg::*;

  localparam int          CLK_PERIOD     = 10;
  localparam int          RESET_CYCLES   = 6;
  localparam int unsigned CORDIC_ITERS   = 16;
  localparam int          SETTLE_CYCLES  = 100;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          IDLE_PCT       = 38;

  localparam logic ACT_CLICK     = 1'b0;
  localparam logic ACT_MAP       = 1'b1;
  localparam logic MODE_CIRCLE   = 1'b0;
  localparam logic MODE_PARALLEL = 1'b1;

  // Register slots past the anchors; writes there are dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam longint DIR_UNIT   = 64'sd65536;
  localparam longint NORM_LEVEL = 64'sd1 << 30;
  localparam longint ROUND_DIR  = 64'sd1 << 13;
  localparam longint ROUND_DIST = 64'sd1 << 25;
  localparam longint ROUND_OFF  = 64'sd1 << 23;
  localparam longint PT_MAX     = longint'(COORD_MAX);
  localparam longint PT_MIN     = longint'(COORD_MIN);

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } snap_t;

  typedef struct packed {
    logic                      act;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      typed;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } probe_t;

  // Directed rows: reset state, extremes, zero vector, left half-plane, tiny vectors
  probe_t probes [0:21] = '{
    '{ACT_MAP,   25'sd0,     25'sd0,     1'b1, 25'sd0,    25'sd0},
    '{ACT_MAP,   25'sd1,     25'sd0,     1'b0, 25'sd0,    25'sd0},
    '{ACT_MAP,   COORD_MAX,  COORD_MAX,  1'b1, COORD_MAX, 25'sd0},
    '{ACT_MAP,   COORD_MIN,  COORD_MIN,  1'b1, COORD_MAX, 25'sd0},
    '{ACT_CLICK, 25'sd0,     25'sd0,     1'b0, 25'sd0,    25'sd0},
    '{ACT_MAP,   25'sd0,     25'sd1000,  1'b0, 25'sd0,    25'sd0},
    '{ACT_MAP,   25'sd0,     25'sd0,     1'b1, 25'sd0,    25'sd0},
    '{ACT_CLICK, COORD_MAX,  COORD_MAX,  1'b0, 25'sd0,    25'sd0},
    '{ACT_MAP,   COORD_MIN,  COORD_MIN,  1'b1, COORD_MAX, COORD_MAX},
    '{ACT_MAP,   COORD_MAX,  COORD_MAX,  1'b1, COORD_MAX, COORD_MAX},
    '{ACT_MAP,   25'sd16776959, COORD_MAX, 1'b0, 25'sd0,  25'sd0},
    '{ACT_CLICK, COORD_MIN,  COORD_MIN,  1'b0, 25'sd0,    25'sd0},
    '{ACT_MAP,   COORD_MAX,  COORD_MAX,  1'b1, COORD_MIN, COORD_MIN},
    '{ACT_MAP,   COORD_MIN,  -25'sd16777215, 1'b0, 25'sd0, 25'sd0},
    '{ACT_CLICK, COORD_MIN,  COORD_MAX,  1'b0, 25'sd0,    25'sd0},
    '{ACT_MAP,   COORD_MAX,  COORD_MIN,  1'b1, COORD_MIN, COORD_MAX},
    '{ACT_CLICK, 25'sd1,     25'sd0,     1'b0, 25'sd0,    25'sd0},
    '{ACT_MAP,   25'sd5,     -25'sd7,    1'b0, 25'sd0,    25'sd0},
    '{ACT_CLICK, 25'sd0,     -25'sd1,    1'b0, 25'sd0,    25'sd0},
    '{ACT_MAP,   25'sd300,   25'sd300,   1'b0, 25'sd0,    25'sd0},
    '{ACT_CLICK, -25'sd1,    25'sd1,     1'b0, 25'sd0,    25'sd0},
    '{ACT_MAP,   -25'sd100000, 25'sd2345, 1'b0, 25'sd0,   25'sd0}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ADDR_W-1:0]   paddr         = '0;
  logic [DATA_W-1:0]   pwdata        = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TDATA_W-1:0]  s_axis_tdata  = '0;  // pos_x[24:0], pos_y[49:25]
  logic                s_axis_tuser  = 1'b0; // action
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;         // snap_x[24:0], snap_y[49:25]

  // Predictor state: ruler setup, click point and unit direction
  logic   rule_mode = MODE_CIRCLE;
  longint a0_x = 0, a0_y = 0, a1_x = 0, a1_y = 0;
  longint pen_x = 0, pen_y = 0;
  longint ray_cos = DIR_UNIT, ray_sin = 0;
  longint gain_q26;

  snap_t  snap_due [$];
  snap_t  want;
  int     fail_count   = 0;
  int     quiet_cycles = 0;
  int     hold_left    = 0;
  bit     hold_req     = 1'b0;
  bit     no_idle      = 1'b0;

  ruler_point_projector #(
    .CORDIC_STEPS (CORDIC_ITERS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic longint clamp_l(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Rotate (x, y) onto the positive x axis; record each rotation sense
  function automatic longint vector_to_axis(input longint x0, input longint y0,
                                            output logic [31:0] turns, output bit flip);
    longint x, y, xs, ys;
    x     = x0;
    y     = y0;
    flip  = (x < 0);
    turns = '0;
    if (flip) begin
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        turns[i] = 1'b1;
      end else begin
        x -= ys;
        y += xs;
      end
    end
    return x;
  endfunction

  // Advance the predictor by one item; returns 1 when a result is due
  function automatic bit predict_snap(input logic act, input logic signed [COORD_W-1:0] px,
                                      input logic signed [COORD_W-1:0] py,
                                      output snap_t snap);
    longint      dx, dy, mag, xf, reach, ox, oy, c, s, cs, ss;
    logic [31:0] turns;
    bit          flip;
    snap = '0;
    if (act == ACT_CLICK) begin
      pen_x = px;
      pen_y = py;
      if (rule_mode == MODE_CIRCLE) begin
        dx = pen_x - a0_x;
        dy = pen_y - a0_y;
      end else begin
        dx = a1_x - a0_x;
        dy = a1_y - a0_y;
      end
      if (dx == 0 && dy == 0) begin
        ray_cos = DIR_UNIT;
        ray_sin = 0;
      end else begin
        // Normalize, vector, then replay the turns on the gain-corrected unit vector
        mag = (dx < 0) ? -dx : dx;
        if (((dy < 0) ? -dy : dy) > mag) mag = (dy < 0) ? -dy : dy;
        while (mag < NORM_LEVEL) begin
          dx  *= 2;
          dy  *= 2;
          mag *= 2;
        end
        void'(vector_to_axis(dx, dy, turns, flip));
        c = gain_q26 * 16;
        s = 0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
          cs = c >>> i;
          ss = s >>> i;
          if (turns[i]) begin
            c -= ss;
            s += cs;
          end else begin
            c += ss;
            s -= cs;
          end
        end
        if (flip) begin
          c = -c;
          s = -s;
        end
        ray_cos = clamp_l((c + ROUND_DIR) >>> 14, -DIR_UNIT, DIR_UNIT);
        ray_sin = clamp_l((s + ROUND_DIR) >>> 14, -DIR_UNIT, DIR_UNIT);
      end
      return 1'b0;
    end
    dx = px - pen_x;
    dy = py - pen_y;
    if (dx == 0 && dy == 0) begin
      reach = 0;
    end else begin
      xf    = vector_to_axis(dx * 256, dy * 256, turns, flip);
      reach = (xf * gain_q26 + ROUND_DIST) >>> 26;
    end
    ox = clamp_l(pen_x + ((reach * ray_cos + ROUND_OFF) >>> 24), PT_MIN, PT_MAX);
    oy = clamp_l(pen_y + ((reach * ray_sin + ROUND_OFF) >>> 24), PT_MIN, PT_MAX);
    snap.x = ox[COORD_W-1:0];
    snap.y = oy[COORD_W-1:0];
    return 1'b1;
  endfunction

  // Coordinate near a base point at a random scale, or full range, or an extreme
  function automatic logic signed [COORD_W-1:0] pick_coord(input longint base);
    longint off;
    case ($urandom_range(9))
      0, 1, 2: return COORD_W'($urandom());
      3: begin
        case ($urandom_range(3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: begin
        off = longint'($signed($urandom())) >>> $urandom_range(31, 6);
        return COORD_W'(base + off);
      end
    endcase
  endfunction

  // APB write: setup then access phase, then the bus is left idle
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE: rule_mode = value[0];
      REG_A0X:  a0_x = longint'($signed(value[COORD_W-1:0]));
      REG_A0Y:  a0_y = longint'($signed(value[COORD_W-1:0]));
      REG_A1X:  a1_x = longint'($signed(value[COORD_W-1:0]));
      REG_A1Y:  a1_y = longint'($signed(value[COORD_W-1:0]));
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Load the whole ruler setup with junk in the unused upper bits
  task automatic load_ruler(input logic mode, input logic signed [COORD_W-1:0] ax,
                            input logic signed [COORD_W-1:0] ay,
                            input logic signed [COORD_W-1:0] bx,
                            input logic signed [COORD_W-1:0] by);
    write_reg(REG_MODE, {31'($urandom()), mode});
    write_reg(REG_A0X, {7'($urandom()), ax});
    write_reg(REG_A0Y, {7'($urandom()), ay});
    write_reg(REG_A1X, {7'($urandom()), bx});
    write_reg(REG_A1Y, {7'($urandom()), by});
    write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom());
  endtask

  // Offer one point with random gaps; predict once the transaction completes
  task automatic feed_point(input logic act, input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py, input logic typed,
                            input logic signed [COORD_W-1:0] ex,
                            input logic signed [COORD_W-1:0] ey);
    snap_t snap;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= TDATA_W'({py, px});
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_snap(act, px, py, snap)) begin
      if (typed) begin
        snap.x = ex;
        snap.y = ey;
      end
      snap_due.push_back(snap);
    end
  endtask

  task automatic random_traffic(input int count);
    logic                      act;
    logic signed [COORD_W-1:0] x, y;
    repeat (count) begin
      act = ($urandom_range(99) < 22) ? ACT_CLICK : ACT_MAP;
      if (act == ACT_CLICK) begin
        x = pick_coord(a0_x);
        y = pick_coord(a0_y);
      end else if ($urandom_range(19) == 0) begin
        x = pen_x[COORD_W-1:0];
        y = pen_y[COORD_W-1:0];
      end else begin
        x = pick_coord(pen_x);
        y = pick_coord(pen_y);
      end
      feed_point(act, x, y, 1'b0, '0, '0);
    end
  endtask

  // Drop valid, drain all results, then cover a trailing click still in flight
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (snap_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result side: random stalls, one long hold-off on request, and checking
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req      = 1'b0;
      hold_left     = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (snap_due.size() == 0) begin
        $error("unexpected result: snap_x %0d snap_y %0d",
               $signed(m_axis_tdata[24:0]), $signed(m_axis_tdata[49:25]));
        fail_count++;
      end else begin
        want = snap_due.pop_front();
        if (m_axis_tdata[24:0] !== want.x) begin
          $error("snap_x: expected %0d, actual %0d",
                 $signed(want.x), $signed(m_axis_tdata[24:0]));
          fail_count++;
        end
        if (m_axis_tdata[49:25] !== want.y) begin
          $error("snap_y: expected %0d, actual %0d",
                 $signed(want.y), $signed(m_axis_tdata[49:25]));
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction completes for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no transaction for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic signed [COORD_W-1:0] ax, ay, bx, by;
    longint unsigned           prod, rem, root, bit_w;

    // Inverse CORDIC gain in Q26: product of step factors, then integer square root
    prod = 64'd1 << 52;
    for (int i = 0; i < CORDIC_ITERS; i++) prod -= prod / ((64'd1 << (2 * i)) + 64'd1);
    rem   = prod;
    root  = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > rem) bit_w >>= 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem  -= root + bit_w;
        root  = (root >> 1) + bit_w;
      end else begin
        root >>= 1;
      end
      bit_w >>= 2;
    end
    gain_q26 = longint'(root);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows against the reset setup
    foreach (probes[i]) begin
      feed_point(probes[i].act, probes[i].px, probes[i].py, probes[i].typed,
                 probes[i].ex, probes[i].ey);
    end
    settle();

    // Circle mode, no idling on either side
    no_idle = 1'b1;
    load_ruler(MODE_CIRCLE, COORD_W'($urandom()), COORD_W'($urandom()),
               COORD_W'($urandom()), COORD_W'($urandom()));
    random_traffic(150);
    settle();
    no_idle = 1'b0;

    // Parallel mode across the full range; hold the result side off to back up the input
    load_ruler(MODE_PARALLEL, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    random_traffic(30);
    hold_req = 1'b1;
    random_traffic(120);
    settle();

    // Parallel mode with coincident anchors gives the default direction
    ax = COORD_W'($urandom());
    ay = COORD_W'($urandom());
    load_ruler(MODE_PARALLEL, ax, ay, ax, ay);
    random_traffic(100);
    settle();

    // Circle mode around a corner anchor
    load_ruler(MODE_CIRCLE, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    random_traffic(150);
    settle();

    // Random setups, anchors at random distances apart
    repeat (5) begin
      ax = pick_coord(0);
      ay = pick_coord(0);
      bx = pick_coord(ax);
      by = pick_coord(ay);
      load_ruler(1'($urandom()), ax, ay, bx, by);
      random_traffic(160);
      settle();
    end

    if (fail_count == 0 && snap_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
